### rtl/rpe_pkg.sv
// Shared types, widths and constants of the rotary position embedding rotator.
// Holds the arctangent table and the elaboration-time root and gain functions.
// No dependencies.
package rpe_pkg;

  localparam int ELEM_W  = 16;
  localparam int POS_W   = 16;
  localparam int IDX_W   = 7;
  localparam int HS_W    = 9;
  localparam int LB_W    = 22;
  localparam int EXP_W   = LB_W + IDX_W + 1;
  localparam int FRAC_W  = 16;
  localparam int INT_W   = EXP_W - FRAC_W;
  localparam int MANT_W  = 31;
  localparam int PHASE_W = 32;
  localparam int CS_W    = 34;
  localparam int CFG_W   = LB_W;
  localparam int ADDR_W  = 1;

  localparam logic [ADDR_W-1:0] REG_HEAD_SIZE = 1'b0;
  localparam logic [ADDR_W-1:0] REG_LOG2_BASE = 1'b1;

  localparam logic [HS_W-1:0] HEAD_SIZE_RST = 9'd128;
  localparam logic [LB_W-1:0] LOG2_BASE_RST = 22'd870817;

  localparam logic [29:0] INV_TWO_PI = 30'd683565276;
  localparam logic [MANT_W-1:0] ONE_Q30 = 31'h4000_0000;

  typedef struct packed {
    logic signed [ELEM_W-1:0] first_elem;
    logic signed [ELEM_W-1:0] second_elem;
    logic [POS_W-1:0]         position;
    logic                     last_pair;
  } side_t;

  localparam logic [29:0] ATAN_TURNS [32] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
  };

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] val;
    logic [63:0] res;
    logic [63:0] bit_v;
    val   = v;
    res   = '0;
    bit_v = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (val >= res + bit_v) begin
        val = val - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int j = 63; j >= 0; j--) begin
      r = {r[63:0], n[j]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [29:0] exp2_root(input int k);
    logic [63:0] t;
    t = 64'd1 << 29;
    for (int j = 1; j <= k; j++) begin
      t = isqrt64(t << 30);
    end
    return t[29:0];
  endfunction

  function automatic logic [31:0] cordic_gain(input int steps);
    logic [63:0] g;
    logic [63:0] d;
    logic [63:0] s;
    g = 64'd1 << 30;
    for (int k = 0; k < 32; k++) begin
      if (k < steps) begin
        d = (k <= 30) ? (64'd1 << (60 - 2 * k)) : 64'd0;
        s = isqrt64((64'd1 << 60) + d);
        g = udiv64(g << 30, s);
      end
    end
    return g[31:0];
  endfunction

endpackage

### rtl/rpe_expo.sv
// Frequency exponent: log2_base * 2i / head_size, floor, as a pipelined divider.
// One multiply stage, then one restoring quotient bit per stage.
// Depends on rpe_pkg.
module rpe_expo #(
  parameter int MAX_HEAD_SIZE = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_vld,
  input  rpe_pkg::side_t                   in_side,
  input  logic [rpe_pkg::IDX_W-1:0]        pair_index,
  input  logic [rpe_pkg::HS_W-1:0]         head_size,
  input  logic [rpe_pkg::LB_W-1:0]         log2_base,
  output logic                             out_vld,
  output rpe_pkg::side_t                   out_side,
  output logic [rpe_pkg::EXP_W-1:0]        expo
);

  localparam int EW = rpe_pkg::EXP_W;
  localparam int HW = rpe_pkg::HS_W;

  logic [HW-1:0] dv;
  logic          vld  [EW+1];
  rpe_pkg::side_t side [EW+1];
  logic [EW-1:0] num  [EW+1];
  logic [HW-1:0] rem  [EW+1];

  always_comb begin
    if (head_size < HW'(2)) begin
      dv = HW'(2);
    end else if (11'(head_size) > 11'(MAX_HEAD_SIZE)) begin
      dv = HW'(MAX_HEAD_SIZE);
    end else begin
      dv = head_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      num[0]  <= EW'(log2_base) * EW'({pair_index, 1'b0});
      rem[0]  <= '0;
    end
  end

  for (genvar j = 0; j < EW; j++) begin : g_bit
    logic [HW:0]   t;
    logic          ge;
    logic [HW-1:0] rem_next;

    assign t        = {rem[j], num[j][EW-1]};
    assign ge       = t >= {1'b0, dv};
    assign rem_next = ge ? HW'(t - {1'b0, dv}) : t[HW-1:0];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[j+1] <= side[j];
        num[j+1]  <= {num[j][EW-2:0], ge};
        rem[j+1]  <= rem_next;
      end
    end
  end

  assign out_vld  = vld[EW];
  assign out_side = side[EW];
  assign expo     = num[EW];

endmodule

### rtl/rpe_exp2.sv
// Fraction mantissa 2^(-f) in Q30: one rounded multiply by a root constant per stage.
// Passes the integer part of the exponent along.
// Depends on rpe_pkg.
module rpe_exp2 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  rpe_pkg::side_t                in_side,
  input  logic [rpe_pkg::EXP_W-1:0]     expo,
  output logic                          out_vld,
  output rpe_pkg::side_t                out_side,
  output logic [rpe_pkg::MANT_W-1:0]    mant,
  output logic [rpe_pkg::INT_W-1:0]     shift_int
);

  localparam int FW = rpe_pkg::FRAC_W;
  localparam int MW = rpe_pkg::MANT_W;
  localparam int IW = rpe_pkg::INT_W;
  localparam int PW = MW + 30;

  logic           vld  [FW];
  rpe_pkg::side_t side [FW];
  logic [MW-1:0]  m    [FW];
  logic [IW-1:0]  n    [FW];
  logic [FW-1:0]  f    [FW];

  for (genvar k = 0; k < FW; k++) begin : g_step
    localparam logic [29:0] ROOT = rpe_pkg::exp2_root(k + 1);
    logic           v_in;
    rpe_pkg::side_t s_in;
    logic [MW-1:0]  m_in;
    logic [IW-1:0]  n_in;
    logic [FW-1:0]  f_in;
    logic [PW-1:0]  prod;

    if (k == 0) begin : g_head
      assign v_in = in_vld;
      assign s_in = in_side;
      assign m_in = rpe_pkg::ONE_Q30;
      assign n_in = expo[rpe_pkg::EXP_W-1:FW];
      assign f_in = expo[FW-1:0];
    end else begin : g_link
      assign v_in = vld[k-1];
      assign s_in = side[k-1];
      assign m_in = m[k-1];
      assign n_in = n[k-1];
      assign f_in = f[k-1];
    end

    assign prod = PW'(m_in) * PW'(ROOT) + (PW'(1) << 29);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[k] <= s_in;
        n[k]    <= n_in;
        f[k]    <= f_in;
        m[k]    <= f_in[FW-1-k] ? MW'(prod >> 30) : m_in;
      end
    end
  end

  assign out_vld   = vld[FW-1];
  assign out_side  = side[FW-1];
  assign mant      = m[FW-1];
  assign shift_int = n[FW-1];

endmodule

### rtl/rpe_phase.sv
// Angle in Q32 turns: position * mantissa * round(2^32 / 2pi), shifted down.
// The wide product is split into two partial products over separate stages.
// Depends on rpe_pkg.
module rpe_phase (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  rpe_pkg::side_t                in_side,
  input  logic [rpe_pkg::MANT_W-1:0]    mant,
  input  logic [rpe_pkg::INT_W-1:0]     shift_int,
  output logic                          out_vld,
  output rpe_pkg::side_t                out_side,
  output logic [rpe_pkg::PHASE_W-1:0]   phase
);

  localparam int IW = rpe_pkg::INT_W;
  localparam int AW = rpe_pkg::POS_W + rpe_pkg::MANT_W;
  localparam int HW = AW - 32;
  localparam int LW = 32 + 30;
  localparam int UW = HW + 30;
  localparam int PW = AW + 30;

  logic v1, v2, v3, v4, v5;
  rpe_pkg::side_t s1, s2, s3, s4, s5;
  logic [IW-1:0] n1, n2, n3, n4;
  logic [AW-1:0] a1;
  logic [LW-1:0] plo2, plo3;
  logic [HW-1:0] ahi2;
  logic [UW-1:0] phi3;
  logic [PW-1:0] p4;
  logic [6:0]    sh;

  assign sh = 7'(n4) + 7'd30;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1    <= in_side;
      n1    <= shift_int;
      a1    <= AW'(in_side.position) * AW'(mant);
      s2    <= s1;
      n2    <= n1;
      plo2  <= LW'(a1[31:0]) * LW'(rpe_pkg::INV_TWO_PI);
      ahi2  <= a1[AW-1:32];
      s3    <= s2;
      n3    <= n2;
      plo3  <= plo2;
      phi3  <= UW'(ahi2) * UW'(rpe_pkg::INV_TWO_PI);
      s4    <= s3;
      n4    <= n3;
      p4    <= PW'(plo3) + (PW'(phi3) << 32);
      s5    <= s4;
      phase <= (n4 >= IW'(PW - 30)) ? '0 : rpe_pkg::PHASE_W'(p4 >> sh);
    end
  end

  assign out_vld  = v5;
  assign out_side = s5;

endmodule

### rtl/rpe_cordic.sv
// Cosine and sine of a Q32-turn phase: quadrant fold, one CORDIC rotation per stage,
// quadrant unfold. Results are Q30.
// Depends on rpe_pkg.
module rpe_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_vld,
  input  rpe_pkg::side_t                    in_side,
  input  logic [rpe_pkg::PHASE_W-1:0]       phase,
  output logic                              out_vld,
  output rpe_pkg::side_t                    out_side,
  output logic signed [rpe_pkg::CS_W-1:0]   cos_v,
  output logic signed [rpe_pkg::CS_W-1:0]   sin_v
);

  localparam int CW = rpe_pkg::CS_W;
  localparam int N  = CORDIC_STEPS;
  localparam logic [31:0] GAIN = rpe_pkg::cordic_gain(CORDIC_STEPS);

  localparam logic [1:0] QD_0 = 2'd0;
  localparam logic [1:0] QD_1 = 2'd1;
  localparam logic [1:0] QD_2 = 2'd2;
  localparam logic [1:0] QD_3 = 2'd3;

  logic                 vld  [N+1];
  rpe_pkg::side_t       side [N+1];
  logic [1:0]           quad [N+1];
  logic signed [CW-1:0] x    [N+1];
  logic signed [CW-1:0] y    [N+1];
  logic signed [CW-1:0] z    [N+1];

  logic [31:0] phase_rnd;
  logic [1:0]  q_w;
  logic [31:0] ru;
  logic        vo;
  rpe_pkg::side_t so;

  assign phase_rnd = phase + 32'h2000_0000;
  assign q_w       = phase_rnd[31:30];
  assign ru        = phase - {q_w, 30'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      quad[0] <= q_w;
      x[0]    <= CW'(GAIN);
      y[0]    <= '0;
      z[0]    <= CW'($signed(ru));
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_rot
    localparam logic [29:0] ANG = (k < 32) ? rpe_pkg::ATAN_TURNS[k % 32] : 30'd0;
    logic signed [CW-1:0] at;
    assign at = CW'(ANG);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[k+1] <= side[k];
        quad[k+1] <= quad[k];
        if (!z[k][CW-1]) begin
          x[k+1] <= x[k] - (y[k] >>> k);
          y[k+1] <= y[k] + (x[k] >>> k);
          z[k+1] <= z[k] - at;
        end else begin
          x[k+1] <= x[k] + (y[k] >>> k);
          y[k+1] <= y[k] - (x[k] >>> k);
          z[k+1] <= z[k] + at;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en) begin
      vo <= vld[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      so <= side[N];
      case (quad[N])
        QD_0: begin
          cos_v <= x[N];
          sin_v <= y[N];
        end
        QD_1: begin
          cos_v <= -y[N];
          sin_v <= x[N];
        end
        QD_2: begin
          cos_v <= -x[N];
          sin_v <= -y[N];
        end
        default: begin
          cos_v <= y[N];
          sin_v <= -x[N];
        end
      endcase
    end
  end

  assign out_vld  = vo;
  assign out_side = so;

endmodule

### rtl/rotary_position_embedding_rotator_core.sv
// Top level of the rotary position embedding rotator: registers, pipeline, rotate, saturate.
// Instantiates rpe_expo, rpe_exp2, rpe_phase and rpe_cordic; depends on rpe_pkg.
//
// channel  | signals                          | contents
// s_axis   | tvalid tready tdata[55:0] tlast  | first_elem, second_elem, pair_index, position
// m_axis   | tvalid tready tdata[31:0] tlast  | rot_first, rot_second; tuser = clipped
// cfg      | cfg_we cfg_addr cfg_data[21:0]   | 0 head_size, 1 log2_base
//
// One pair per cycle unless m_axis stalls; the depth is set by the 30-bit quotient chain,
// the 16 mantissa steps and the CORDIC rotation stages.
// rst clears valid bits and loads the register defaults; data registers are not reset.
// A stall on m_axis freezes every stage at once; s_axis_tready follows the output register.
module rotary_position_embedding_rotator_core #(
  parameter int MAX_HEAD_SIZE = 256,
  parameter int CORDIC_STEPS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // first_elem[15:0], second_elem[31:16], pair_index[38:32], position[54:39], zero[55]
  input  logic [55:0]                   s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // rot_first[15:0], rot_second[31:16]
  output logic [31:0]                   m_axis_tdata,
  output logic                          m_axis_tlast,
  // clipped[0]
  output logic                          m_axis_tuser,
  input  logic                          cfg_we,
  input  logic [rpe_pkg::ADDR_W-1:0]    cfg_addr,
  input  logic [rpe_pkg::CFG_W-1:0]     cfg_data
);

  localparam int EW = rpe_pkg::ELEM_W;
  localparam int CW = rpe_pkg::CS_W;
  localparam int PW = EW + CW;
  localparam int SW = PW + 1;

  logic [rpe_pkg::HS_W-1:0] head_size;
  logic [rpe_pkg::LB_W-1:0] log2_base;
  logic en;

  rpe_pkg::side_t in_side;
  logic [rpe_pkg::IDX_W-1:0] pair_index;

  logic e_vld, x_vld, p_vld, c_vld;
  rpe_pkg::side_t e_side, x_side, p_side, c_side, r_side;
  logic [rpe_pkg::EXP_W-1:0]   expo;
  logic [rpe_pkg::MANT_W-1:0]  mant;
  logic [rpe_pkg::INT_W-1:0]   shift_int;
  logic [rpe_pkg::PHASE_W-1:0] phase;
  logic signed [CW-1:0] cos_v, sin_v;

  logic r_vld;
  logic signed [PW-1:0] ac, bs, bc, as_p;
  logic signed [SW-1:0] sum0, sum1;
  logic [EW:0] sat0, sat1;

  function automatic logic [EW:0] sat_round(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = v >>> 30;
    if (r > SW'(32767)) begin
      return {1'b1, 16'h7FFF};
    end else if (r < -SW'(32768)) begin
      return {1'b1, 16'h8000};
    end
    return {1'b0, r[EW-1:0]};
  endfunction

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  assign in_side.first_elem  = s_axis_tdata[15:0];
  assign in_side.second_elem = s_axis_tdata[31:16];
  assign in_side.position    = s_axis_tdata[54:39];
  assign in_side.last_pair   = s_axis_tlast;
  assign pair_index          = s_axis_tdata[38:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      head_size <= rpe_pkg::HEAD_SIZE_RST;
      log2_base <= rpe_pkg::LOG2_BASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rpe_pkg::REG_HEAD_SIZE: head_size <= cfg_data[rpe_pkg::HS_W-1:0];
        rpe_pkg::REG_LOG2_BASE: log2_base <= cfg_data;
      endcase
    end
  end

  rpe_expo #(.MAX_HEAD_SIZE(MAX_HEAD_SIZE)) u_expo (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(s_axis_tvalid), .in_side(in_side), .pair_index(pair_index),
    .head_size(head_size), .log2_base(log2_base),
    .out_vld(e_vld), .out_side(e_side), .expo(expo)
  );

  rpe_exp2 u_exp2 (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(e_vld), .in_side(e_side), .expo(expo),
    .out_vld(x_vld), .out_side(x_side), .mant(mant), .shift_int(shift_int)
  );

  rpe_phase u_phase (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(x_vld), .in_side(x_side), .mant(mant), .shift_int(shift_int),
    .out_vld(p_vld), .out_side(p_side), .phase(phase)
  );

  rpe_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(p_vld), .in_side(p_side), .phase(phase),
    .out_vld(c_vld), .out_side(c_side), .cos_v(cos_v), .sin_v(sin_v)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld         <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      r_vld         <= c_vld;
      m_axis_tvalid <= r_vld;
    end
  end

  assign sum0 = SW'(ac) - SW'(bs) + (SW'(1) <<< 29);
  assign sum1 = SW'(bc) + SW'(as_p) + (SW'(1) <<< 29);
  assign sat0 = sat_round(sum0);
  assign sat1 = sat_round(sum1);

  always_ff @(posedge clk) begin
    if (en) begin
      r_side       <= c_side;
      ac           <= PW'(c_side.first_elem) * PW'(cos_v);
      bs           <= PW'(c_side.second_elem) * PW'(sin_v);
      bc           <= PW'(c_side.second_elem) * PW'(cos_v);
      as_p         <= PW'(c_side.first_elem) * PW'(sin_v);
      m_axis_tdata <= {sat1[EW-1:0], sat0[EW-1:0]};
      m_axis_tlast <= r_side.last_pair;
      m_axis_tuser <= sat0[EW] | sat1[EW];
    end
  end

endmodule
